// ===== hw/rtl/rrs_pkg.sv =====
package rrs_pkg;

    // Payload widths
    localparam int unsigned PROC_W  = 10;
    localparam int unsigned BURST_W = 32;
    localparam int unsigned TIME_W  = 48;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    // Default ready queue depth
    localparam int unsigned QUEUE_DEPTH_DEF = 64;

    // Result buffer depth (power of two, holds at least two results)
    localparam int unsigned OUT_DEPTH = 4;

    localparam logic [TIME_W-1:0]  TIME_MAX    = {TIME_W{1'b1}};
    localparam logic [BURST_W-1:0] QUANTUM_RST = BURST_W'(1);

    // Request types
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_START  = 2'd0;
    localparam logic [KIND_W-1:0] EV_FINISH = 2'd1;
    localparam logic [KIND_W-1:0] EV_SWITCH = 2'd2;
    localparam logic [KIND_W-1:0] EV_REJECT = 2'd3;

    // Register index (paddr[2])
    localparam logic REG_QUANTUM = 1'b0;

    // One ready queue entry
    typedef struct packed {
        logic [PROC_W-1:0]  id;
        logic [BURST_W-1:0] left;
        logic               started;
    } qentry_t;

    // One result
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PROC_W-1:0] proc;
        logic [TIME_W-1:0] time_val;
        logic              last;
    } result_t;

endpackage

// ===== hw/rtl/rrs_req_if.sv =====
interface rrs_req_if
    import rrs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [PROC_W-1:0]  proc_id;
    logic [BURST_W-1:0] burst_len;

    modport source (output valid, req_type, proc_id, burst_len, input ready);
    modport sink   (input valid, req_type, proc_id, burst_len, output ready);
endinterface

// ===== hw/rtl/rrs_evt_if.sv =====
interface rrs_evt_if
    import rrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [PROC_W-1:0] event_proc;
    logic [TIME_W-1:0] event_time;
    logic              last;

    modport source (output valid, event_kind, event_proc, event_time, last, input ready);
    modport sink   (input valid, event_kind, event_proc, event_time, last, output ready);
endinterface

// ===== hw/rtl/round_robin_scheduler.sv =====
// Channel   Direction  Payload
// req_ch    in         req_type, proc_id, burst_len
// evt_ch    out        event_kind, event_proc, event_time, last
// APB       in/out     quantum register at byte address 0
//
// One request is taken per cycle while req_ch.ready is high; its results (zero to two) land in a
// four-entry result buffer on the same edge and leave one per cycle while evt_ch.ready is high.
// req_ch.ready drops while the result buffer has fewer than two free slots.
// The ready queue head is held in a registered read of the queue memory,
// prefetched from the next head slot with a bypass for a write to that slot.
// rst_n resets all control state; queue memory contents need no reset.
module round_robin_scheduler
    import rrs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    rrs_req_if.sink            req_ch,
    rrs_evt_if.source          evt_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned OPTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);

    // Control and state registers
    logic [BURST_W-1:0] quantum_reg;
    logic [TIME_W-1:0]  time_reg,    time_next;
    logic               busy_reg,    busy_next;
    logic [PROC_W-1:0]  run_id_reg,  run_id_next;
    logic [BURST_W-1:0] run_left_reg, run_left_next;
    logic [BURST_W-1:0] slice_reg,   slice_next;
    logic [PTR_W-1:0]   head_reg,    head_next;
    logic [PTR_W-1:0]   tail_reg,    tail_next;
    logic [CNT_W-1:0]   count_reg,   count_next;

    // Queue memory and head prefetch
    qentry_t            qmem [QUEUE_DEPTH];
    qentry_t            rd_reg;
    qentry_t            byp_reg;
    logic               byp_valid_reg;
    qentry_t            head_ent;
    logic               wr_en;
    qentry_t            wr_data;

    // Result buffer
    result_t            ofifo [OUT_DEPTH];
    logic [OPTR_W-1:0]  owp_reg, orp_reg;
    logic [OCNT_W-1:0]  ocnt_reg;
    logic [1:0]         n_res;
    result_t            res0, res1;

    logic               req_acc, evt_acc;
    logic [BURST_W-1:0] eff_q;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign eff_q    = (quantum_reg == '0) ? QUANTUM_RST : quantum_reg;
    assign head_ent = byp_valid_reg ? byp_reg : rd_reg;

    // Handshakes
    assign req_ch.ready = (ocnt_reg <= OCNT_W'(OUT_DEPTH - 2));
    assign req_acc      = req_ch.valid && req_ch.ready;
    assign evt_ch.valid = (ocnt_reg != '0);
    assign evt_acc      = evt_ch.valid && evt_ch.ready;

    assign evt_ch.event_kind = ofifo[orp_reg].kind;
    assign evt_ch.event_proc = ofifo[orp_reg].proc;
    assign evt_ch.event_time = ofifo[orp_reg].time_val;
    assign evt_ch.last       = ofifo[orp_reg].last;

    // APB register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUANTUM) ? quantum_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_QUANTUM)
        begin
            quantum_reg <= pwdata;
        end
    end

    // Scheduling step for one request
    always_comb
    begin
        logic               pop;
        logic [PROC_W-1:0]  cur_id;
        logic [BURST_W-1:0] cur_left;
        logic [BURST_W-1:0] cur_slice;
        logic               cur_busy;
        logic [CNT_W-1:0]   cnt1;
        logic               ev_start;
        logic               ev_b;
        result_t            rb;

        time_next     = time_reg;
        busy_next     = busy_reg;
        run_id_next   = run_id_reg;
        run_left_next = run_left_reg;
        slice_next    = slice_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        wr_en         = 1'b0;
        wr_data       = '0;
        n_res         = 2'd0;
        res0          = '0;
        res1          = '0;
        pop           = 1'b0;
        cur_id        = run_id_reg;
        cur_left      = run_left_reg;
        cur_slice     = slice_reg;
        cur_busy      = busy_reg;
        cnt1          = count_reg;
        ev_start      = 1'b0;
        ev_b          = 1'b0;
        rb            = '0;

        if (req_acc)
        begin
            if (req_ch.req_type == REQ_ARRIVAL)
            begin
                // Arrival: enqueue or reject
                if (req_ch.burst_len == '0 || count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    res0  = '{kind: EV_REJECT, proc: req_ch.proc_id,
                              time_val: time_reg, last: 1'b1};
                    n_res = 2'd1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{id: req_ch.proc_id, left: req_ch.burst_len,
                                   started: 1'b0};
                    tail_next  = next_slot(tail_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                // Dispatch from queue head if idle
                pop = !busy_reg && (count_reg != '0);
                if (pop)
                begin
                    cur_id    = head_ent.id;
                    cur_left  = head_ent.left;
                    cur_slice = eff_q;
                    cur_busy  = 1'b1;
                    cnt1      = count_reg - 1'b1;
                    head_next = next_slot(head_reg);
                    ev_start  = !head_ent.started;
                end

                // Run one unit
                if (cur_busy)
                begin
                    if (cur_left != '0) cur_left = cur_left - 1'b1;
                    if (cur_slice != '0) cur_slice = cur_slice - 1'b1;
                end
                time_next = (time_reg != TIME_MAX) ? time_reg + 1'b1 : time_reg;

                // Finish or slice expiry
                count_next = cnt1;
                if (cur_busy)
                begin
                    if (cur_left == '0)
                    begin
                        ev_b      = 1'b1;
                        rb        = '{kind: EV_FINISH, proc: cur_id,
                                      time_val: time_next, last: 1'b1};
                        cur_busy  = 1'b0;
                        cur_slice = eff_q;
                    end
                    else if (cur_slice == '0)
                    begin
                        if (cnt1 != '0 && cnt1 != CNT_W'(QUEUE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            wr_data    = '{id: cur_id, left: cur_left, started: 1'b1};
                            tail_next  = next_slot(tail_reg);
                            count_next = cnt1 + 1'b1;
                            ev_b       = 1'b1;
                            rb         = '{kind: EV_SWITCH, proc: cur_id,
                                           time_val: time_next, last: 1'b1};
                            cur_busy   = 1'b0;
                        end
                        cur_slice = eff_q;
                    end
                end
                busy_next     = cur_busy;
                run_id_next   = cur_id;
                run_left_next = cur_left;
                slice_next    = cur_slice;

                // Pack results in order
                if (ev_start)
                begin
                    res0  = '{kind: EV_START, proc: cur_id,
                              time_val: time_reg, last: !ev_b};
                    res1  = rb;
                    n_res = ev_b ? 2'd2 : 2'd1;
                end
                else if (ev_b)
                begin
                    res0  = rb;
                    n_res = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            busy_reg     <= 1'b0;
            run_id_reg   <= '0;
            run_left_reg <= '0;
            slice_reg    <= QUANTUM_RST;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            time_reg     <= time_next;
            busy_reg     <= busy_next;
            run_id_reg   <= run_id_next;
            run_left_reg <= run_left_next;
            slice_reg    <= slice_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
        end
    end

    // Queue memory: write at tail, prefetch the next head slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            qmem[tail_reg] <= wr_data;
        end
        rd_reg  <= qmem[head_next];
        byp_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= wr_en && (tail_reg == head_next);
        end
    end

    // Result buffer storage
    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            ofifo[owp_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            ofifo[owp_reg + 1'b1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= '0;
            orp_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            owp_reg  <= owp_reg + OPTR_W'(n_res);
            orp_reg  <= orp_reg + OPTR_W'(evt_acc);
            ocnt_reg <= ocnt_reg + OCNT_W'(n_res) - OCNT_W'(evt_acc);
        end
    end

endmodule
